>>> rtl/core/ftba_pkg.sv
// Shared types and constants of the frame-tagged block allocator.
`timescale 1ns / 1ps
package ftba_pkg;

  localparam int FRAME_W = 32;
  localparam int SIZE_W  = 32;
  localparam int BLK_W   = 4;
  localparam int BYTES_W = 17;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // status of one block entry against the request in flight
  typedef struct packed {
    logic finished;
    logic mine;
    logic fits;
    logic roomier;
  } eval_flags_t;

endpackage

>>> rtl/core/ftba_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ftba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/ftba_eval.sv
// Shared block evaluation unit: age, ownership, room and free-space compares.
`timescale 1ns / 1ps
module ftba_eval #(
  parameter int BLOCK_BYTES = 65536,
  parameter int FILL_W      = 17
) (
  input  logic                          owner_null,
  input  logic [ftba_pkg::FRAME_W-1:0]  owner,
  input  logic [FILL_W-1:0]             fill,
  input  logic                          thr_ok,
  input  logic [ftba_pkg::FRAME_W-1:0]  thr,
  input  logic [ftba_pkg::FRAME_W-1:0]  frame,
  input  logic [ftba_pkg::SIZE_W-1:0]   size,
  input  logic [FILL_W-1:0]             most_free,
  output ftba_pkg::eval_flags_t         flags,
  output logic [FILL_W-1:0]             free_bytes,
  output logic [FILL_W-1:0]             fill_eff
);

  localparam int SW = ftba_pkg::SIZE_W;
  localparam logic [FILL_W-1:0] BB = FILL_W'(BLOCK_BYTES);

  logic finished;

  // null marker is older than any frame; otherwise owner <= frame - lag
  assign finished   = owner_null || (thr_ok && (owner <= thr));
  assign fill_eff   = finished ? '0 : fill;   // finished blocks count as empty
  assign free_bytes = BB - fill_eff;

  assign flags.finished = finished;
  assign flags.mine     = !owner_null && (owner == frame);
  // fill + size < BB  <=>  size < free
  assign flags.fits     = size < {{(SW-FILL_W){1'b0}}, free_bytes};
  assign flags.roomier  = free_bytes > most_free;

endmodule

>>> rtl/core/frame_tagged_block_allocator.sv
// Top level of the frame-tagged block allocator: sequencer, block store, result register.
`timescale 1ns / 1ps
// Allocator over up to MAX_BLOCKS blocks of BLOCK_BYTES bytes, each tagged with the
// frame that owns it and bump-allocated. One item is worked on at a time; in_ready
// is high only while the sequencer is idle, but a finished result may still sit in
// the output register when the next item is taken. Block owner and fill live in a
// RAM with one read and one write port; every step below is bounded by that single
// read port and the one shared evaluation unit, which looks at one block per cycle.
// An allocate served by the current block goes from acceptance straight to the grant step.
// When the current block is full or foreign, a scan over the blocks in use comes
// first; if nothing fits and no block is left to add, a forced reclaim pass over
// all MAX_BLOCKS blocks follows. A clear item is one scan over the blocks in use.
// No clearing pass is needed after reset: a valid bit per block makes an unwritten
// block read as empty and owned by the null frame.
module frame_tagged_block_allocator #(
  parameter int BLOCK_BYTES = 65536,
  parameter int MAX_BLOCKS  = 16,
  parameter int LAG_FRAMES  = 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_opcode,
  input  logic [ftba_pkg::FRAME_W-1:0]  in_frame_number,
  input  logic [ftba_pkg::SIZE_W-1:0]   in_request_bytes,
  input  logic                          in_may_split,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ftba_pkg::BLK_W-1:0]    out_granted_block,
  output logic [ftba_pkg::BYTES_W-1:0]  out_granted_offset,
  output logic [ftba_pkg::BYTES_W-1:0]  out_granted_bytes,
  output logic                          out_reclaimed_all
);

  localparam int FW       = ftba_pkg::FRAME_W;
  localparam int SW       = ftba_pkg::SIZE_W;
  localparam int BW       = ftba_pkg::BLK_W;
  localparam int YW       = ftba_pkg::BYTES_W;
  localparam int IDX_W    = $clog2(MAX_BLOCKS);
  localparam int CNT_W    = $clog2(MAX_BLOCKS + 1);
  localparam int FILL_W   = $clog2(BLOCK_BYTES + 1);
  localparam int ENT_W    = 1 + FW + FILL_W;   // {null, owner, fill}
  localparam int USED_RST = (LAG_FRAMES < MAX_BLOCKS) ? LAG_FRAMES : MAX_BLOCKS;

  localparam logic [FW-1:0]    LAG_X  = FW'(LAG_FRAMES);
  localparam logic [CNT_W-1:0] MAX_X  = CNT_W'(MAX_BLOCKS);
  localparam logic [FILL_W:0]  BB_X   = (FILL_W + 1)'(BLOCK_BYTES);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CUR   = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_GRANT = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  // scan pass kinds
  localparam logic [1:0] MD_FIND    = 2'd0;  // look for a fitting / emptiest block
  localparam logic [1:0] MD_RECLAIM = 2'd1;  // free every block not owned by frame
  localparam logic [1:0] MD_CLEAR   = 2'd2;  // hand finished blocks to frame

  // control state
  logic [2:0]        state_r, state_nxt;
  logic [1:0]        mode_r, mode_nxt;
  logic [IDX_W-1:0]  cur_r, cur_nxt;
  logic [CNT_W-1:0]  used_r, used_nxt;
  logic [CNT_W-1:0]  rd_cnt_r, rd_cnt_nxt;
  logic              p_vld_r, p_vld_nxt;
  logic              settled_r, settled_nxt;
  logic              found_r, found_nxt;
  logic              out_valid_r;
  logic [MAX_BLOCKS-1:0] valid_r;

  // request and working payload
  logic              op_r, op_nxt;
  logic [FW-1:0]     frame_r, frame_nxt;
  logic [SW-1:0]     size_r, size_nxt;
  logic              split_r, split_nxt;
  logic              thr_ok_r, thr_ok_nxt;
  logic [FW-1:0]     thr_r, thr_nxt;
  logic              reclaim_r, reclaim_nxt;
  logic [IDX_W-1:0]  p_idx_r, p_idx_nxt;
  logic [FILL_W-1:0] most_free_r, most_free_nxt;
  logic [IDX_W-1:0]  sel_idx_r, sel_idx_nxt;
  logic [FILL_W-1:0] sel_fill_r, sel_fill_nxt;
  logic [FILL_W-1:0] gsize_r, gsize_nxt;
  logic              rd_v_r;

  // output register
  logic [BW-1:0]     out_block_r;
  logic [YW-1:0]     out_offset_r;
  logic [YW-1:0]     out_bytes_r;
  logic              out_reclaim_r;
  logic              out_load;

  // block store
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [ENT_W-1:0]  ram_wdata;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [ENT_W-1:0]  ram_rdata;

  // entry as read, with never-written blocks shown at their reset value
  logic              ent_null;
  logic [FW-1:0]     ent_owner;
  logic [FILL_W-1:0] ent_fill;

  // shared evaluation unit
  logic              ev_null;
  logic [FW-1:0]     ev_owner;
  logic [FILL_W-1:0] ev_fill;
  ftba_pkg::eval_flags_t ev;
  logic [FILL_W-1:0] ev_free;
  logic [FILL_W-1:0] ev_fill_eff;

  logic              scan_issue;
  logic [SW-1:0]     sel_idx_ext;
  logic [SW-1:0]     sel_fill_ext;
  logic [SW-1:0]     gsize_ext;

  ftba_ram #(
    .WIDTH(ENT_W),
    .DEPTH(MAX_BLOCKS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ent_null  = !rd_v_r || ram_rdata[ENT_W-1];
  assign ent_owner = ram_rdata[FILL_W +: FW];
  assign ent_fill  = rd_v_r ? ram_rdata[FILL_W-1:0] : '0;

  // the grant step reuses the unit on the selected block, owned by frame
  assign ev_null  = (state_r == S_GRANT) ? 1'b0 : ent_null;
  assign ev_owner = (state_r == S_GRANT) ? frame_r : ent_owner;
  assign ev_fill  = (state_r == S_GRANT) ? sel_fill_r : ent_fill;

  ftba_eval #(
    .BLOCK_BYTES(BLOCK_BYTES),
    .FILL_W     (FILL_W)
  ) u_eval (
    .owner_null (ev_null),
    .owner      (ev_owner),
    .fill       (ev_fill),
    .thr_ok     (thr_ok_r),
    .thr        (thr_r),
    .frame      (frame_r),
    .size       (size_r),
    .most_free  (most_free_r),
    .flags      (ev),
    .free_bytes (ev_free),
    .fill_eff   (ev_fill_eff)
  );

  assign in_ready   = (state_r == S_IDLE);
  assign scan_issue = (rd_cnt_r < used_r);

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    cur_nxt       = cur_r;
    used_nxt      = used_r;
    rd_cnt_nxt    = rd_cnt_r;
    p_vld_nxt     = p_vld_r;
    settled_nxt   = settled_r;
    found_nxt     = found_r;
    op_nxt        = op_r;
    frame_nxt     = frame_r;
    size_nxt      = size_r;
    split_nxt     = split_r;
    thr_ok_nxt    = thr_ok_r;
    thr_nxt       = thr_r;
    reclaim_nxt   = reclaim_r;
    p_idx_nxt     = p_idx_r;
    most_free_nxt = most_free_r;
    sel_idx_nxt   = sel_idx_r;
    sel_fill_nxt  = sel_fill_r;
    gsize_nxt     = gsize_r;
    ram_we        = 1'b0;
    ram_waddr     = p_idx_r;
    ram_wdata     = {1'b1, {FW{1'b0}}, {FILL_W{1'b0}}};
    ram_re        = 1'b0;
    ram_raddr     = cur_r;
    out_load      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt        = in_opcode;
          frame_nxt     = in_frame_number;
          size_nxt      = in_request_bytes;
          split_nxt     = in_may_split;
          thr_ok_nxt    = (in_frame_number >= LAG_X);
          thr_nxt       = in_frame_number - LAG_X;
          reclaim_nxt   = 1'b0;
          rd_cnt_nxt    = '0;
          p_vld_nxt     = 1'b0;
          settled_nxt   = 1'b0;
          found_nxt     = 1'b0;
          most_free_nxt = '0;
          // current block is fetched up front; a clear ignores it
          ram_re        = 1'b1;
          ram_raddr     = cur_r;
          if (in_opcode == ftba_pkg::OP_CLEAR) begin
            mode_nxt  = MD_CLEAR;
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_CUR;
          end
        end
      end

      S_CUR: begin
        // keeps the current block's fill as fallback for a reclaim that frees nothing
        sel_idx_nxt  = cur_r;
        sel_fill_nxt = ev_fill_eff;
        if ((ev.mine && ev.fits) || ev.finished) begin
          state_nxt = S_GRANT;
        end else begin
          mode_nxt  = MD_FIND;
          state_nxt = S_SCAN;
        end
      end

      S_SCAN: begin
        // read one block per cycle, evaluate it the cycle after
        if (scan_issue) begin
          ram_re     = 1'b1;
          ram_raddr  = rd_cnt_r[IDX_W-1:0];
          rd_cnt_nxt = rd_cnt_r + CNT_W'(1);
        end
        p_vld_nxt = scan_issue;
        p_idx_nxt = rd_cnt_r[IDX_W-1:0];

        if (p_vld_r) begin
          unique case (mode_r)
            MD_FIND: begin
              // finished blocks met on the way are emptied, even after a pick
              if (ev.finished) begin
                ram_we = 1'b1;
              end
              if ((ev.finished || ev.mine) && !settled_r) begin
                if (ev.fits) begin
                  sel_idx_nxt  = p_idx_r;
                  sel_fill_nxt = ev_fill_eff;
                  settled_nxt  = 1'b1;
                  found_nxt    = 1'b1;
                end else if (split_r && ev.roomier) begin
                  sel_idx_nxt   = p_idx_r;
                  sel_fill_nxt  = ev_fill_eff;
                  most_free_nxt = ev_free;
                  found_nxt     = 1'b1;
                end
              end
            end
            MD_RECLAIM: begin
              if (!ev.mine) begin
                ram_we = 1'b1;
                if (!settled_r) begin
                  sel_idx_nxt  = p_idx_r;
                  sel_fill_nxt = '0;
                  settled_nxt  = 1'b1;
                end
              end
            end
            MD_CLEAR: begin
              if (ev.finished) begin
                ram_we    = 1'b1;
                ram_wdata = {1'b0, frame_r, {FILL_W{1'b0}}};
              end
            end
            default: begin
            end
          endcase
        end

        if (!p_vld_r && !scan_issue) begin
          unique case (mode_r)
            MD_FIND: begin
              if (found_r) begin
                state_nxt = S_GRANT;
              end else if (used_r < MAX_X) begin
                // open a fresh block at the end
                sel_idx_nxt  = used_r[IDX_W-1:0];
                sel_fill_nxt = '0;
                used_nxt     = used_r + CNT_W'(1);
                state_nxt    = S_GRANT;
              end else begin
                mode_nxt    = MD_RECLAIM;
                reclaim_nxt = 1'b1;
                rd_cnt_nxt  = '0;
                settled_nxt = 1'b0;
              end
            end
            MD_RECLAIM: begin
              state_nxt = S_GRANT;
            end
            MD_CLEAR: begin
              state_nxt = S_DONE;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_GRANT: begin
        // clip to the space left in the selected block
        gsize_nxt = ev.fits ? size_r[FILL_W-1:0] : ev_free;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load = 1'b1;
          if (op_r == ftba_pkg::OP_ALLOC) begin
            ram_we    = 1'b1;
            ram_waddr = sel_idx_r;
            ram_wdata = {1'b0, frame_r, sel_fill_r + gsize_r};
            cur_nxt   = sel_idx_r;
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign sel_idx_ext  = SW'(sel_idx_r);
  assign sel_fill_ext = SW'(sel_fill_r);
  assign gsize_ext    = SW'(gsize_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= MD_FIND;
      cur_r       <= '0;
      used_r      <= CNT_W'(USED_RST);
      rd_cnt_r    <= '0;
      p_vld_r     <= 1'b0;
      settled_r   <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      mode_r    <= mode_nxt;
      cur_r     <= cur_nxt;
      used_r    <= used_nxt;
      rd_cnt_r  <= rd_cnt_nxt;
      p_vld_r   <= p_vld_nxt;
      settled_r <= settled_nxt;
      found_r   <= found_nxt;
      if (ram_we) begin
        valid_r[ram_waddr] <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    frame_r     <= frame_nxt;
    size_r      <= size_nxt;
    split_r     <= split_nxt;
    thr_ok_r    <= thr_ok_nxt;
    thr_r       <= thr_nxt;
    reclaim_r   <= reclaim_nxt;
    p_idx_r     <= p_idx_nxt;
    most_free_r <= most_free_nxt;
    sel_idx_r   <= sel_idx_nxt;
    sel_fill_r  <= sel_fill_nxt;
    gsize_r     <= gsize_nxt;
    if (ram_re) begin
      rd_v_r <= valid_r[ram_raddr];
    end
    if (out_load) begin
      if (op_r == ftba_pkg::OP_ALLOC) begin
        out_block_r   <= sel_idx_ext[BW-1:0];
        out_offset_r  <= sel_fill_ext[YW-1:0];
        out_bytes_r   <= gsize_ext[YW-1:0];
        out_reclaim_r <= reclaim_r;
      end else begin
        out_block_r   <= '0;
        out_offset_r  <= '0;
        out_bytes_r   <= '0;
        out_reclaim_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_granted_block  = out_block_r;
  assign out_granted_offset = out_offset_r;
  assign out_granted_bytes  = out_bytes_r;
  assign out_reclaimed_all  = out_reclaim_r;

`ifndef SYNTH
  // block count never passes the pool size
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= MAX_X)
    else $error("blocks in use exceeds pool size");

  // current block is always one that exists
  a_cur_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    CNT_W'(cur_r) < used_r)
    else $error("current block outside blocks in use");

  // store writes only touch blocks that exist
  a_write_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (CNT_W'(ram_waddr) < used_r))
    else $error("write to a block not in use");

  // a grant never runs past the end of its block
  a_grant_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && op_r == ftba_pkg::OP_ALLOC) |->
      (({1'b0, sel_fill_r} + {1'b0, gsize_r}) <= BB_X))
    else $error("grant overruns block");
`endif

endmodule

>>> dv/frame_tagged_block_allocator_test.sv
// Self-checking testbench for the frame-tagged block allocator: directed and random items.
`timescale 1ns / 1ps
module frame_tagged_block_allocator_test;

  localparam int BLOCK_BYTES  = 65536;
  localparam int MAX_BLOCKS   = 16;
  localparam int LAG_FRAMES   = 2;
  localparam longint NULL_FRAME = -longint'(LAG_FRAMES) - 1;

  localparam int RANDOM_ITEMS = 750;
  // no short random idling on either side once the queue of pending items is this short
  localparam int CALM_TAIL    = 100;
  localparam int DRAIN_CYCLES = 60;
  localparam int LONG_STALL   = 80;

  // one input item, or a marker that makes the sender wait for all results
  typedef struct {
    logic        op;
    logic [31:0] frame;
    logic [31:0] nbytes;
    logic        split;
    bit          pause_mark;
  } req_t;

  typedef struct packed {
    logic [ftba_pkg::BLK_W-1:0]   blk;
    logic [ftba_pkg::BYTES_W-1:0] offset;
    logic [ftba_pkg::BYTES_W-1:0] nbytes;
    logic                         reclaimed;
  } grant_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic                          in_opcode = ftba_pkg::OP_ALLOC;
  logic [ftba_pkg::FRAME_W-1:0]  in_frame_number = '0;
  logic [ftba_pkg::SIZE_W-1:0]   in_request_bytes = '0;
  logic                          in_may_split = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [ftba_pkg::BLK_W-1:0]    out_granted_block;
  logic [ftba_pkg::BYTES_W-1:0]  out_granted_offset;
  logic [ftba_pkg::BYTES_W-1:0]  out_granted_bytes;
  logic                          out_reclaimed_all;

  frame_tagged_block_allocator #(
    .BLOCK_BYTES(BLOCK_BYTES),
    .MAX_BLOCKS (MAX_BLOCKS),
    .LAG_FRAMES (LAG_FRAMES)
  ) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_frame_number   (in_frame_number),
    .in_request_bytes  (in_request_bytes),
    .in_may_split      (in_may_split),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_granted_block (out_granted_block),
    .out_granted_offset(out_granted_offset),
    .out_granted_bytes (out_granted_bytes),
    .out_reclaimed_all (out_reclaimed_all)
  );

  always #2 clk = ~clk;

  req_t   pending_reqs[$];
  grant_t expected_grants[$];
  req_t   next_req;
  int     errors = 0;
  int     grants_seen = 0;
  bit     in_fire = 1'b0;
  int     send_gap = 0;
  int     stall_left = 0;
  int     next_long_stall = 150;

  // Allocator state as the predictor sees it. Owners are signed so that the
  // null marker always reads as a finished frame.
  longint      blk_owner[MAX_BLOCKS];
  longint      blk_fill[MAX_BLOCKS];
  int unsigned cur_blk;
  int unsigned live_blocks;

  function automatic void clear_allocator();
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      blk_owner[i] = NULL_FRAME;
      blk_fill[i] = 0;
    end
    cur_blk = 0;
    live_blocks = (LAG_FRAMES < MAX_BLOCKS) ? LAG_FRAMES : MAX_BLOCKS;
  endfunction

  function automatic bit frame_done(longint owner, longint frame);
    return owner <= frame - LAG_FRAMES;
  endfunction

  // Walk the blocks in use: first fit wins, else (with split) the emptiest.
  // Finished blocks met on the way are emptied even after a winner is found.
  function automatic int scan_for_room(longint frame, longint size, bit split);
    int     pick;
    bit     settled;
    bit     done;
    longint most_free;
    pick = -1;
    settled = 1'b0;
    most_free = 0;
    for (int i = 0; i < live_blocks && i < MAX_BLOCKS; i++) begin
      done = frame_done(blk_owner[i], frame);
      if (!done && blk_owner[i] != frame) continue;
      if (done) begin
        blk_fill[i] = 0;
        blk_owner[i] = NULL_FRAME;
      end
      if (settled) continue;
      if (blk_fill[i] + size < BLOCK_BYTES) begin
        pick = i;
        settled = 1'b1;
      end else if (split && BLOCK_BYTES - blk_fill[i] > most_free) begin
        pick = i;
        most_free = BLOCK_BYTES - blk_fill[i];
      end
    end
    if (pick >= 0) blk_owner[pick] = frame;
    return pick;
  endfunction

  // Scan, then add a block, then force a reclaim; returns 1 on the reclaim path.
  function automatic bit move_elsewhere(longint frame, longint size, bit split);
    int found;
    bit got;
    got = 1'b0;
    found = scan_for_room(frame, size, split);
    if (found >= 0) begin
      cur_blk = found;
      return 1'b0;
    end
    if (live_blocks < MAX_BLOCKS) begin
      cur_blk = live_blocks;
      blk_fill[cur_blk] = 0;
      blk_owner[cur_blk] = frame;
      live_blocks++;
      return 1'b0;
    end
    for (int i = 0; i < live_blocks && i < MAX_BLOCKS; i++) begin
      if (blk_owner[i] != frame) begin
        blk_fill[i] = 0;
        blk_owner[i] = NULL_FRAME;
        if (!got) begin
          got = 1'b1;
          cur_blk = i;
          blk_owner[i] = frame;
        end
      end
    end
    return 1'b1;
  endfunction

  // Updates the predicted state for one accepted item and returns its grant.
  function automatic grant_t serve_request(logic op, logic [31:0] frame_in,
                                           logic [31:0] bytes_in, logic split);
    longint      frame;
    longint      size;
    longint      offset;
    int unsigned b;
    bit          reclaimed;
    grant_t      g;
    frame = frame_in;
    size = bytes_in;
    reclaimed = 1'b0;
    g = '0;
    if (op == ftba_pkg::OP_CLEAR) begin
      // finished blocks are recycled straight to the new frame
      for (int i = 0; i < live_blocks && i < MAX_BLOCKS; i++) begin
        if (frame_done(blk_owner[i], frame)) begin
          blk_fill[i] = 0;
          blk_owner[i] = frame;
        end
      end
      return g;
    end
    cur_blk = cur_blk % MAX_BLOCKS;
    if (blk_owner[cur_blk] == frame) begin
      if (blk_fill[cur_blk] + size >= BLOCK_BYTES)
        reclaimed = move_elsewhere(frame, size, split);
    end else if (frame_done(blk_owner[cur_blk], frame)) begin
      blk_fill[cur_blk] = 0;
      blk_owner[cur_blk] = frame;
    end else begin
      reclaimed = move_elsewhere(frame, size, split);
    end
    b = cur_blk % MAX_BLOCKS;
    offset = blk_fill[b];
    if (offset + size >= BLOCK_BYTES) size = BLOCK_BYTES - offset;
    blk_fill[b] = offset + size;
    g.blk = b[ftba_pkg::BLK_W-1:0];
    g.offset = offset[ftba_pkg::BYTES_W-1:0];
    g.nbytes = size[ftba_pkg::BYTES_W-1:0];
    g.reclaimed = reclaimed;
    return g;
  endfunction

  function automatic void flag_field(string fname, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
      errors++;
    end
  endfunction

  function automatic void queue_req(req_t r);
    pending_reqs.insert(pending_reqs.size(), r);
  endfunction

  function automatic void add_alloc(logic [31:0] frame, logic [31:0] nbytes, logic split);
    req_t r;
    r = '{ftba_pkg::OP_ALLOC, frame, nbytes, split, 1'b0};
    queue_req(r);
  endfunction

  function automatic void add_clear(logic [31:0] frame);
    req_t r;
    r = '{ftba_pkg::OP_CLEAR, frame, $urandom(), 1'($urandom_range(0, 1)), 1'b0};
    queue_req(r);
  endfunction

  function automatic void add_pause();
    req_t r;
    r = '{ftba_pkg::OP_ALLOC, 32'd0, 32'd0, 1'b0, 1'b1};
    queue_req(r);
  endfunction

  // Monitor: check results against the oldest grant, then record accepted items.
  always @(posedge clk) begin
    grant_t want;
    if (rst_n && out_valid && out_ready) begin
      grants_seen++;
      if (expected_grants.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual block %0d offset %0d bytes %0d",
                 $time, out_granted_block, out_granted_offset, out_granted_bytes);
        errors++;
      end else begin
        want = expected_grants.pop_front();
        flag_field("granted_block", want.blk, out_granted_block);
        flag_field("granted_offset", want.offset, out_granted_offset);
        flag_field("granted_bytes", want.nbytes, out_granted_bytes);
        flag_field("reclaimed_all", want.reclaimed, out_reclaimed_all);
      end
    end
    in_fire = rst_n && in_valid && in_ready;
    if (in_fire)
      expected_grants.insert(expected_grants.size(),
                             serve_request(in_opcode, in_frame_number,
                                           in_request_bytes, in_may_split));
  end

  // Driver: holds an offered item until taken, idles in short bursts, and
  // waits for all outstanding results at each pause marker.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
      // item still waiting for in_ready
    end else if (send_gap > 0) begin
      send_gap--;
      in_valid <= 1'b0;
    end else if (pending_reqs.size() == 0) begin
      in_valid <= 1'b0;
    end else if (pending_reqs[0].pause_mark) begin
      in_valid <= 1'b0;
      if (expected_grants.size() == 0) void'(pending_reqs.pop_front());
    end else if (pending_reqs.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
      send_gap = $urandom_range(0, 6);
      in_valid <= 1'b0;
    end else begin
      next_req = pending_reqs.pop_front();
      in_opcode <= next_req.op;
      in_frame_number <= next_req.frame;
      in_request_bytes <= next_req.nbytes;
      in_may_split <= next_req.split;
      in_valid <= 1'b1;
    end
  end

  // Receiver: short random stalls, plus long hold-offs that back the block up
  // into its input while the driver keeps offering.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (grants_seen >= next_long_stall) begin
      next_long_stall = (next_long_stall < 400) ? 500 : 32'h7FFF_FFFF;
      stall_left = LONG_STALL - 1;
      out_ready <= 1'b0;
    end else if (pending_reqs.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 6);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    int unsigned frame_ctr;
    int unsigned fr;
    int unsigned sz;
    int          per_frame;
    int          next_pause;
    int          total_items;
    bit          heavy;

    clear_allocator();

    // Directed: empty request on a fresh block, a huge request that forces a
    // new block, split into the emptiest block, clears, exact-size request.
    add_alloc(32'd0, 32'd0, 1'b0);
    add_alloc(32'd0, 32'd100, 1'b0);
    add_alloc(32'd0, 32'hFFFF_FFFF, 1'b0);
    add_alloc(32'd0, 32'd65535, 1'b1);
    add_alloc(32'd0, 32'd70000, 1'b1);
    add_clear(32'd1);
    add_clear(32'd5);
    add_alloc(32'd5, BLOCK_BYTES, 1'b0);
    // whole-block requests grow the set to its limit, then the forced
    // reclaim finds every block owned by this frame and grants nothing
    repeat (13) add_alloc(32'd5, 32'hFFFF_FFFF, 1'b0);
    add_alloc(32'd5, 32'd1, 1'b1);
    // top frame id, then a frame far behind it: reclaim frees foreign blocks
    add_alloc(32'hFFFF_FFFF, 32'd12345, 1'b1);
    add_clear(32'hFFFF_FFFF);
    add_alloc(32'd3, 32'd4096, 1'b0);
    add_alloc(32'd3, 32'd61440, 1'b1);

    // Random: frames move forward, each with a burst of requests; a few
    // heavy frames push the block count to its limit; rare noise items.
    frame_ctr = 10;
    next_pause = pending_reqs.size() + 250;
    total_items = pending_reqs.size() + RANDOM_ITEMS;
    while (pending_reqs.size() < total_items) begin
      frame_ctr += ($urandom_range(0, 9) == 0) ? $urandom_range(2, 5) : 1;
      if (pending_reqs.size() >= next_pause) begin
        add_pause();
        next_pause += 250;
      end
      if ($urandom_range(0, 2) == 0) add_clear(frame_ctr);
      heavy = ($urandom_range(0, 9) == 0);
      per_frame = heavy ? $urandom_range(12, 24) : $urandom_range(1, 10);
      repeat (per_frame) begin
        case ($urandom_range(0, 19))
          0:       sz = 0;
          1:       sz = $urandom();
          2:       sz = BLOCK_BYTES - $urandom_range(0, 1);
          3, 4, 5: sz = $urandom_range(20000, 65535);
          default: sz = $urandom_range(1, 16000);
        endcase
        if (heavy) sz = $urandom_range(24000, 65535);
        fr = frame_ctr;
        case ($urandom_range(0, 49))
          0:       fr = $urandom();
          1:       fr = frame_ctr - $urandom_range(1, 3);
          2:       begin add_clear(frame_ctr - $urandom_range(0, 3)); end
          default: ;
        endcase
        add_alloc(fr, sz, 1'($urandom_range(0, 1)));
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || in_valid) @(posedge clk);
    while (expected_grants.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && expected_grants.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hang guard: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/ftba_pkg.sv
rtl/core/ftba_ram.sv
rtl/core/ftba_eval.sv
rtl/core/frame_tagged_block_allocator.sv
dv/frame_tagged_block_allocator_test.sv
